[rtl/isms_pkg.sv]
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants for the interval set merge table.
// ----------------------------------------------------------------------------
package isms_pkg;

	localparam int MAX_RANGES_DEF = 64;

	typedef struct packed {
		logic        op;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} isms_req_t;

	typedef struct packed {
		logic       overlap_found;
		logic       table_full;
		logic [6:0] stored_ranges;
	} isms_rsp_t;

	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_EVAL   = 3'd1,
		CELL_INSERT = 3'd2,
		CELL_ABSORB = 3'd3,
		CELL_FINAL  = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      query;
	} cell_ctl_t;

endpackage

[rtl/isms_cell.sv]
// ----------------------------------------------------------------------------
// isms_cell
// One table slot: holds a range, compares it against the broadcast range and
// shifts toward either neighbor on insert or compaction.
// ----------------------------------------------------------------------------
module isms_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  isms_pkg::cell_ctl_t ctl,
	input  logic [31:0]         rng_lo,
	input  logic [31:0]         rng_hi,
	input  logic [CNT_W-1:0]    count,
	input  logic                left_pos,
	input  logic                left_mark,
	input  logic [31:0]         left_lo,
	input  logic [31:0]         left_hi,
	input  logic                right_pos,
	input  logic                right_mark,
	input  logic [31:0]         right_lo,
	input  logic [31:0]         right_hi,
	output logic [31:0]         lo,
	output logic [31:0]         hi,
	output logic                pos,
	output logic                mark
);

	logic [31:0] lo_q, hi_q;
	logic        pos_q, mark_q;
	logic        used, below, above, ovl, first, ins_slot;

	always_comb begin
		used     = count > CNT_W'(IDX);
		below    = used && (({1'b0, hi_q} + 33'd1) < {1'b0, rng_lo});
		above    = used && ({1'b0, lo_q} > ({1'b0, rng_hi} + 33'd1));
		ovl      = used && (lo_q <= rng_hi) && (hi_q >= rng_lo);
		first    = mark_q && !left_mark;
		ins_slot = pos_q && !left_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 1'b1;
			mark_q <= 1'b0;
		end else begin
			unique case (ctl.cmd)
				isms_pkg::CELL_EVAL: begin
					pos_q  <= !below;
					mark_q <= ctl.query ? ovl : (used && !below && !above);
				end
				isms_pkg::CELL_ABSORB: begin
					if (pos_q && !first) begin
						pos_q  <= right_pos;
						mark_q <= right_mark;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			isms_pkg::CELL_INSERT: begin
				if (ins_slot) begin
					lo_q <= rng_lo;
					hi_q <= rng_hi;
				end else if (left_pos) begin
					lo_q <= left_lo;
					hi_q <= left_hi;
				end
			end
			isms_pkg::CELL_ABSORB: begin
				if (first) begin
					hi_q <= right_hi;
				end else if (pos_q) begin
					lo_q <= right_lo;
					hi_q <= right_hi;
				end
			end
			isms_pkg::CELL_FINAL: begin
				if (first) begin
					if (rng_lo < lo_q)
						lo_q <= rng_lo;
					if (rng_hi > hi_q)
						hi_q <= rng_hi;
				end
			end
			default: ;
		endcase
	end

	assign lo   = lo_q;
	assign hi   = hi_q;
	assign pos  = pos_q;
	assign mark = mark_q;

endmodule

[rtl/interval_set_merge_table.sv]
// ----------------------------------------------------------------------------
// interval_set_merge_table
// Sorted table of disjoint inclusive address ranges with overlap query and
// coalescing insert, built as a chain of range cells.
// ----------------------------------------------------------------------------
// Each item is accepted when the block is idle and is handled in an evaluate
// step, in which every cell compares its range against the item's range, and
// an apply step, in which the controller applies the result. An insert that
// merges m stored ranges adds one absorb step per merged range beyond the
// first, since each extra merged range is absorbed by the first merged cell
// while the cells behind it move one slot toward the head. A result waiting
// in the output register does not block acceptance; the final step of the
// next item waits for that register to drain. Table contents are undefined
// after reset and only the first stored_ranges cells are ever looked at.
module interval_set_merge_table #(
	parameter int MAX_RANGES = isms_pkg::MAX_RANGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  isms_pkg::isms_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output isms_pkg::isms_rsp_t rsp
);

	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BUSY = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                op_q;
	logic [31:0]         lo_q, hi_q;
	isms_pkg::isms_rsp_t rsp_q, res;
	logic                rsp_valid_q;

	isms_pkg::cell_ctl_t ctl;
	logic [31:0]         rng_lo, rng_hi;
	logic [31:0]         lo_w [MAX_RANGES];
	logic [31:0]         hi_w [MAX_RANGES];
	logic [MAX_RANGES-1:0] pos_v, mark_v;
	logic                any_mark, any_pair, out_free, done;

	assign any_mark = |mark_v;
	assign any_pair = |(mark_v[MAX_RANGES-2:0] & mark_v[MAX_RANGES-1:1]);
	assign out_free = !rsp_valid_q || rsp_ready;

	genvar k;
	generate
		for (k = 0; k < MAX_RANGES; k++) begin : g_cell
			logic        l_pos, l_mark, r_pos, r_mark;
			logic [31:0] l_lo, l_hi, r_lo, r_hi;

			if (k == 0) begin : g_head
				assign l_pos  = 1'b0;
				assign l_mark = 1'b0;
				assign l_lo   = '0;
				assign l_hi   = '0;
			end else begin : g_left
				assign l_pos  = pos_v[k-1];
				assign l_mark = mark_v[k-1];
				assign l_lo   = lo_w[k-1];
				assign l_hi   = hi_w[k-1];
			end

			if (k == MAX_RANGES - 1) begin : g_tail
				assign r_pos  = 1'b1;
				assign r_mark = 1'b0;
				assign r_lo   = '0;
				assign r_hi   = '0;
			end else begin : g_right
				assign r_pos  = pos_v[k+1];
				assign r_mark = mark_v[k+1];
				assign r_lo   = lo_w[k+1];
				assign r_hi   = hi_w[k+1];
			end

			isms_cell #(
				.IDX   (k),
				.CNT_W (CNT_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.rng_lo     (rng_lo),
				.rng_hi     (rng_hi),
				.count      (count_q),
				.left_pos   (l_pos),
				.left_mark  (l_mark),
				.left_lo    (l_lo),
				.left_hi    (l_hi),
				.right_pos  (r_pos),
				.right_mark (r_mark),
				.right_lo   (r_lo),
				.right_hi   (r_hi),
				.lo         (lo_w[k]),
				.hi         (hi_w[k]),
				.pos        (pos_v[k]),
				.mark       (mark_v[k])
			);
		end
	endgenerate

	always_comb begin
		ctl.cmd   = isms_pkg::CELL_HOLD;
		ctl.query = (req.op == isms_pkg::OP_QUERY);
		rng_lo    = lo_q;
		rng_hi    = hi_q;
		done      = 1'b0;
		count_d   = count_q;
		res       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.cmd = isms_pkg::CELL_EVAL;
					rng_lo  = req.range_start;
					rng_hi  = req.range_end;
				end
			end
			S_BUSY: begin
				if (op_q == isms_pkg::OP_QUERY) begin
					done              = out_free;
					res.overlap_found = any_mark;
				end else if (lo_q > hi_q) begin
					done = out_free;
				end else if (!any_mark) begin
					if (count_q == CNT_W'(MAX_RANGES)) begin
						done           = out_free;
						res.table_full = 1'b1;
					end else if (out_free) begin
						ctl.cmd = isms_pkg::CELL_INSERT;
						count_d = count_q + CNT_W'(1);
						done    = 1'b1;
					end
				end else if (any_pair) begin
					ctl.cmd = isms_pkg::CELL_ABSORB;
					count_d = count_q - CNT_W'(1);
				end else if (out_free) begin
					ctl.cmd = isms_pkg::CELL_FINAL;
					done    = 1'b1;
				end
			end
			default: ;
		endcase
		res.stored_ranges = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			unique case (state_q)
				S_IDLE: if (req_valid) state_q <= S_BUSY;
				S_BUSY: if (done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (done)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req.op;
			lo_q <= req.range_start;
			hi_q <= req.range_end;
		end
		if (done)
			rsp_q <= res;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RANGES))
		else $error("range count above capacity");

	a_merge_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY) && (op_q == isms_pkg::OP_INSERT) && (lo_q <= hi_q) |->
		$onehot0(mark_v & ~{mark_v[MAX_RANGES-2:0], 1'b0}))
		else $error("merge cells not contiguous");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> (state_q == S_BUSY) && !req_ready)
		else $error("accepted item not in progress");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_BUSY))
		else $error("result raised outside item processing");

endmodule

[dv/interval_set_merge_table_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_set_merge_table_test
// Self-checking bench for the interval set merge table. A clocked driver
// feeds query and insert items from a queue, and a clocked monitor checks
// each result against an in-bench table model. Stimulus mixes dense
// insert/query bursts in 4 KB address windows, fill runs that push the
// table to full, window sweeps that merge many entries, and wide random
// noise. Back-pressure varies by phase.
// ----------------------------------------------------------------------------
module interval_set_merge_table_test;

	localparam int TABLE_DEPTH = isms_pkg::MAX_RANGES_DEF;
	localparam int ITEM_TARGET = 1850;
	localparam int QUIET_LIMIT = 4000;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		isms_pkg::isms_req_t item;
		int                  phase;
		bit                  drain;
	} stim_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	isms_pkg::isms_req_t req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	isms_pkg::isms_rsp_t rsp;

	stim_t               pending[$];
	isms_pkg::isms_rsp_t expected_rsp[$];
	int                  cur_phase = 0;
	int                  n_items   = 0;
	int                  errors    = 0;

	int        send_idle[3] = '{7, 83, 0};
	int        recv_stall[3] = '{83, 7, 0};

	// table model
	logic [31:0] held_lo[TABLE_DEPTH];
	logic [31:0] held_hi[TABLE_DEPTH];
	int          held_count = 0;

	int n_queries = 0, n_hits = 0, n_inserts = 0, n_refused = 0;
	int n_multi_merge = 0, peak_count = 0;

	interval_set_merge_table #(
		.MAX_RANGES(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	function automatic isms_pkg::isms_rsp_t table_outcome(isms_pkg::isms_req_t item);
		isms_pkg::isms_rsp_t res;
		int                  first, last, merged, k;
		logic [31:0]         new_lo, new_hi;
		res = '0;
		if (item.op == isms_pkg::OP_QUERY) begin
			n_queries++;
			for (k = 0; k < held_count; k++) begin
				if (held_lo[k] <= item.range_end && held_hi[k] >= item.range_start)
					res.overlap_found = 1'b1;
			end
			if (res.overlap_found)
				n_hits++;
		end else if (item.range_start <= item.range_end) begin
			n_inserts++;
			new_lo = item.range_start;
			new_hi = item.range_end;
			first = 0;
			while (first < held_count &&
			       {1'b0, held_hi[first]} + 33'd1 < {1'b0, item.range_start})
				first++;
			last = first;
			while (last < held_count &&
			       {1'b0, held_lo[last]} <= {1'b0, item.range_end} + 33'd1) begin
				if (held_lo[last] < new_lo)
					new_lo = held_lo[last];
				if (held_hi[last] > new_hi)
					new_hi = held_hi[last];
				last++;
			end
			merged = last - first;
			if (merged == 0 && held_count >= TABLE_DEPTH) begin
				res.table_full = 1'b1;
				n_refused++;
			end else begin
				if (merged == 0) begin
					for (k = held_count; k > first; k--) begin
						held_lo[k] = held_lo[k - 1];
						held_hi[k] = held_hi[k - 1];
					end
					held_count++;
				end else begin
					for (k = last; k < held_count; k++) begin
						held_lo[k - merged + 1] = held_lo[k];
						held_hi[k - merged + 1] = held_hi[k];
					end
					held_count = held_count - merged + 1;
					if (merged > 1)
						n_multi_merge++;
				end
				held_lo[first] = new_lo;
				held_hi[first] = new_hi;
				if (held_count > peak_count)
					peak_count = held_count;
			end
		end
		res.stored_ranges = held_count[6:0];
		return res;
	endfunction

	task automatic add_item(logic op, logic [31:0] first_addr, logic [31:0] last_addr,
	                        bit drain);
		stim_t s;
		s.item.op          = op;
		s.item.range_start = first_addr;
		s.item.range_end   = last_addr;
		s.phase            = (n_items * 3) / ITEM_TARGET;
		if (s.phase > 2)
			s.phase = 2;
		s.drain = drain;
		pending.push_back(s);
		if (!(op == isms_pkg::OP_INSERT && first_addr > last_addr))
			n_items++;
	endtask

	task automatic note_mismatch(string field, logic [6:0] want, logic [6:0] got);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp.push_back(table_outcome(req));
			if (!req_valid || req_ready) begin
				if (pending.size() > 0 &&
				    !(pending[0].drain && expected_rsp.size() > 0) &&
				    $urandom_range(0, 99) >= send_idle[pending[0].phase]) begin
					req_valid <= 1'b1;
					req       <= pending[0].item;
					cur_phase <= pending[0].phase;
					void'(pending.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		isms_pkg::isms_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display("%0t: unexpected item, got %p", $time, rsp);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.overlap_found !== want.overlap_found)
						note_mismatch("overlap_found", 7'(want.overlap_found),
						              7'(rsp.overlap_found));
					if (rsp.table_full !== want.table_full)
						note_mismatch("table_full", 7'(want.table_full),
						              7'(rsp.table_full));
					if (rsp.stored_ranges !== want.stored_ranges)
						note_mismatch("stored_ranges", want.stored_ranges, rsp.stored_ranges);
				end
			end
			rsp_ready <= $urandom_range(0, 99) >= recv_stall[cur_phase];
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("interval_set_merge_table: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] base, lo, hi, tmp;
		logic [32:0] sum;
		int          kind, stride, k;

		// directed: field extremes, bridging, adjacency at both ends, inverted
		add_item(isms_pkg::OP_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0002, 32'h0000_0005, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0001, 32'h0000_0001, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0007, 32'h0000_0009, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0006, 32'h0000_0006, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h0000_0020, 32'h0000_0010, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h0000_0020, 32'h0000_0010, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_000F, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h8000_0020, 32'h8000_002F, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h7FFF_FFF0, 32'h8000_0025, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h8000_0030, 32'h8000_0030, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_item(isms_pkg::OP_INSERT, 32'h4000_0000, 32'hBFFF_FFFF, 1'b1);
		add_item(isms_pkg::OP_QUERY,  32'h0000_0005, 32'h0000_0005, 1'b0);
		add_item(isms_pkg::OP_QUERY,  32'h0000_000A, 32'h3FFF_FFFF, 1'b0);

		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0:       base = 32'h0000_0000;
				1:       base = 32'hFFFF_F000;
				default: base = $urandom & 32'hFFFF_F000;
			endcase
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				repeat ($urandom_range(10, 40)) begin
					lo = $urandom_range(0, 4095);
					hi = lo + $urandom_range(0, 15);
					if (hi > 4095)
						hi = 4095;
					if ($urandom_range(0, 19) == 0) begin
						tmp = lo;
						lo  = hi + 1;
						hi  = tmp;
					end
					add_item($urandom_range(0, 9) < 6 ? isms_pkg::OP_INSERT : isms_pkg::OP_QUERY,
					         base + lo, base + hi, 1'b0);
				end
				if ($urandom_range(0, 1))
					add_item(isms_pkg::OP_INSERT, base, base + 32'd4095, 1'b0);
			end else if (kind == 6) begin
				// fill run: spaced entries that never touch, past table capacity
				stride = $urandom_range(3, 50);
				for (k = 0; k < TABLE_DEPTH + 6; k++) begin
					lo = base + k * stride;
					add_item(isms_pkg::OP_INSERT, lo, lo + $urandom_range(0, stride - 2),
					         k == 0);
				end
				repeat (3) begin
					lo = base + $urandom_range(0, 4095);
					add_item(isms_pkg::OP_QUERY, lo, lo, 1'b0);
				end
				add_item(isms_pkg::OP_INSERT, base, base + 32'd4095, 1'b1);
			end else if (kind <= 8) begin
				repeat (10) begin
					lo  = $urandom;
					sum = {1'b0, lo} + {1'b0, $urandom >> $urandom_range(7, 31)};
					hi  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if ($urandom_range(0, 3) == 0)
						hi = $urandom;
					add_item($urandom_range(0, 1) ? isms_pkg::OP_INSERT : isms_pkg::OP_QUERY,
					         lo, hi, 1'b0);
				end
			end else begin
				repeat (20) begin
					lo = $urandom_range(0, 4095);
					hi = lo + $urandom_range(0, 255);
					if (hi > 4095)
						hi = 4095;
					add_item(isms_pkg::OP_QUERY, base + lo, base + hi, 1'b0);
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (expected_rsp.size() > 0) begin
			errors++;
			$display("%0t: %0d expected items never arrived", $time, expected_rsp.size());
		end
		$display("ran %0d queries (%0d hits) and %0d inserts (%0d refused full, %0d multi-merge)",
		         n_queries, n_hits, n_inserts, n_refused, n_multi_merge);
		$display("peak occupancy %0d of %0d entries, %0d check failures",
		         peak_count, TABLE_DEPTH, errors);
		if (errors == 0)
			$display("interval_set_merge_table: match");
		else
			$display("interval_set_merge_table: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/isms_pkg.sv
rtl/isms_cell.sv
rtl/interval_set_merge_table.sv
dv/interval_set_merge_table_test.sv
